[hw/rtl/beq_pkg.sv]
// shared types, codes and constants for the button event queue
package beq_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned NUM_BUTTONS_DEF = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 8;

  // press counter limits
  localparam logic [7:0] CNT_MAX   = 8'd250;
  localparam logic [7:0] CNT_PRESS = 8'd2;

  // configuration register
  localparam logic [7:0] LONG_PRESS_RESET = 8'd100;
  localparam logic [0:0] REG_LONG_PRESS   = 1'b0;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_POP    = 2'd1,
    OP_PUSH   = 2'd2
  } op_e;

  // button event codes
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_LONG    = 2'd2,
    EV_RELEASE = 2'd3
  } ev_e;

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic step;      // input transaction accepted this cycle
    logic load_pop;  // move the registered queue read into the result
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pop_hit;   // current input is a pop on a non-empty queue
  } dp_status_t;

endpackage

[hw/rtl/button_event_queue.sv]
// top level of the button event queue: controller, datapath and register port
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+----------------------------------------------
//  input    | in_valid_i  | in_stall_o  | operation, button_index, pin_level, event_base,
//           |             |             | event_value
//  result   | out_valid_o | out_stall_i | event_valid, event_code, button_event,
//           |             |             | dropped, pressed_now, queue_count
//  config   | psel/penable| pready = 1  | paddr, pwdata, prdata (long_press_ticks at 0)
//
// sample, push and unused operations have their result registered in the cycle after they are taken.
// a pop on a non-empty queue first reads the registered queue memory, then loads the result in the pop state.
// the next transaction is taken while a result waits, unless that result is stalled or a pop read is under way.
// reset clears counters, pointers and fill level at once; the queue memory is not cleared.
module button_event_queue #(
  parameter int unsigned NUM_BUTTONS = beq_pkg::NUM_BUTTONS_DEF,
  parameter int unsigned QUEUE_DEPTH = beq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [1:0]  button_index_i,
  input  logic        pin_level_i,
  input  logic [7:0]  event_base_i,
  input  logic [7:0]  event_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        event_valid_o,
  output logic [7:0]  event_code_o,
  output logic [1:0]  button_event_o,
  output logic        dropped_o,
  output logic        pressed_now_o,
  output logic [3:0]  queue_count_o
);

  beq_pkg::ctrl_cmd_t  cmd;
  beq_pkg::dp_status_t status;
  logic                cfg_wr;

  // register write strobe
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  beq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  beq_datapath #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_wr_i       (cfg_wr),
    .cfg_addr_i     (paddr),
    .cfg_wdata_i    (pwdata),
    .cfg_rdata_o    (prdata),
    .operation_i    (operation_i),
    .button_index_i (button_index_i),
    .pin_level_i    (pin_level_i),
    .event_base_i   (event_base_i),
    .event_value_i  (event_value_i),
    .event_valid_o  (event_valid_o),
    .event_code_o   (event_code_o),
    .button_event_o (button_event_o),
    .dropped_o      (dropped_o),
    .pressed_now_o  (pressed_now_o),
    .queue_count_o  (queue_count_o)
  );

endmodule

[hw/rtl/beq_ctrl.sv]
// controller state machine: input and result handshakes, pop read sequencing
module beq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  beq_pkg::dp_status_t  status_i,
  output beq_pkg::ctrl_cmd_t   cmd_o
);

  beq_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            in_accept;
  logic            out_taken;

  // handshakes
  assign out_taken  = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != beq_pkg::ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      beq_pkg::ST_IDLE: begin
        if (in_accept && status_i.pop_hit) state_d = beq_pkg::ST_POP;
      end
      beq_pkg::ST_POP: begin
        state_d = beq_pkg::ST_IDLE;
      end
      default: state_d = beq_pkg::ST_IDLE;
    endcase
  end

  // outputs and result valid
  always_comb begin
    cmd_o.step     = in_accept;
    cmd_o.load_pop = (state_q == beq_pkg::ST_POP);
    out_valid_d    = out_valid_q && !out_taken;
    if (in_accept && !status_i.pop_hit) out_valid_d = 1'b1;
    if (state_q == beq_pkg::ST_POP) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= beq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // the result slot is free while the queue read is pending
  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == beq_pkg::ST_POP) |-> !out_valid_q)
    else $error("result slot busy during pop read");

  // an accepted pop on a non-empty queue goes to the read state
  a_pop_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && status_i.pop_hit) |=> (state_q == beq_pkg::ST_POP))
    else $error("pop read not started");

  // the pop read always ends with a valid result
  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == beq_pkg::ST_POP) |=> (out_valid_q && state_q == beq_pkg::ST_IDLE))
    else $error("pop result not delivered");

endmodule

[hw/rtl/beq_datapath.sv]
// datapath: press counters, event queue memory, pointers and result register
module beq_datapath #(
  parameter int unsigned NUM_BUTTONS = beq_pkg::NUM_BUTTONS_DEF,
  parameter int unsigned QUEUE_DEPTH = beq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  beq_pkg::ctrl_cmd_t   cmd_i,
  output beq_pkg::dp_status_t  status_o,
  input  logic                 cfg_wr_i,
  input  logic [2:0]           cfg_addr_i,
  input  logic [31:0]          cfg_wdata_i,
  output logic [31:0]          cfg_rdata_o,
  input  logic [1:0]           operation_i,
  input  logic [1:0]           button_index_i,
  input  logic                 pin_level_i,
  input  logic [7:0]           event_base_i,
  input  logic [7:0]           event_value_i,
  output logic                 event_valid_o,
  output logic [7:0]           event_code_o,
  output logic [1:0]           button_event_o,
  output logic                 dropped_o,
  output logic                 pressed_now_o,
  output logic [3:0]           queue_count_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]             long_press_q;
  logic [7:0]             cnt_q [NUM_BUTTONS];
  logic [7:0]             mem_q [QUEUE_DEPTH];
  logic [7:0]             rd_data_q;
  logic [PTR_W-1:0]       wp_q, rp_q, wp_next, rp_next;
  logic [CNT_W-1:0]       held_q, held_d;

  logic [NUM_BUTTONS-1:0] btn_hit;
  logic                   idx_ok;
  logic [7:0]             cur, c_inc, c_new, c_after;
  beq_pkg::ev_e           ev, bev;
  logic                   do_sample, push_req, push_ok, pop_hit, full, drop;
  logic [7:0]             push_code;

  logic                   ev_valid_q;
  logic [7:0]             code_q;
  logic [1:0]             bev_q;
  logic                   drop_q, pnow_q;
  logic [3:0]             qcnt_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= beq_pkg::LONG_PRESS_RESET;
    end else if (cfg_wr_i && cfg_addr_i[2] == beq_pkg::REG_LONG_PRESS) begin
      long_press_q <= cfg_wdata_i[7:0];
    end
  end

  assign cfg_rdata_o = (cfg_addr_i[2] == beq_pkg::REG_LONG_PRESS) ?
                       {24'd0, long_press_q} : 32'd0;

  // addressed counter select
  always_comb begin
    cur = 8'd0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      btn_hit[b] = (5'(button_index_i) == 5'(b));
      cur        = cur | (btn_hit[b] ? cnt_q[b] : 8'd0);
    end
    idx_ok = |btn_hit;
  end

  // counter update and button event
  always_comb begin
    c_inc = (cur < beq_pkg::CNT_MAX) ? cur + 8'd1 : cur;
    c_new = cur;
    ev    = beq_pkg::EV_NONE;
    if (!pin_level_i) begin
      c_new = c_inc;
      if (c_inc == beq_pkg::CNT_PRESS) ev = beq_pkg::EV_PRESS;
      else if (c_inc == long_press_q) ev = beq_pkg::EV_LONG;
    end else if (cur == 8'd1) begin
      c_new = 8'd0;
      ev    = beq_pkg::EV_RELEASE;
    end else if (cur > 8'd1) begin
      c_new = 8'd1;
    end
  end

  // operation decode
  always_comb begin
    do_sample = 1'b0;
    push_req  = 1'b0;
    push_code = event_value_i;
    pop_hit   = 1'b0;
    case (beq_pkg::op_e'(operation_i))
      beq_pkg::OP_SAMPLE: begin
        do_sample = idx_ok;
        push_req  = idx_ok && (ev != beq_pkg::EV_NONE);
        push_code = 8'({6'd0, ev}) + event_base_i;
      end
      beq_pkg::OP_POP: begin
        pop_hit = (held_q != '0);
      end
      beq_pkg::OP_PUSH: begin
        push_req = 1'b1;
      end
      default: begin
        push_req = 1'b0;
      end
    endcase
    full    = (held_q == CNT_W'(QUEUE_DEPTH));
    push_ok = push_req && !full;
    drop    = push_req && full;
    bev     = do_sample ? ev : beq_pkg::EV_NONE;
    c_after = do_sample ? c_new : cur;
  end

  assign status_o.pop_hit = pop_hit;

  // queue pointers and fill level
  always_comb begin
    wp_next = (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
    rp_next = (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
    held_d  = held_q;
    if (cmd_i.step && push_ok) held_d = held_q + CNT_W'(1);
    else if (cmd_i.step && pop_hit) held_d = held_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      held_q <= '0;
    end else begin
      held_q <= held_d;
      if (cmd_i.step && push_ok) wp_q <= wp_next;
      if (cmd_i.step && pop_hit) rp_q <= rp_next;
    end
  end

  // press counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BUTTONS; b++) cnt_q[b] <= 8'd0;
    end else if (cmd_i.step && do_sample) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        if (btn_hit[b]) cnt_q[b] <= c_new;
      end
    end
  end

  // event queue memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && push_ok) mem_q[wp_q] <= push_code;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && pop_hit) rd_data_q <= mem_q[rp_q];
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      ev_valid_q <= 1'b0;
      code_q     <= 8'd0;
      bev_q      <= bev;
      drop_q     <= drop;
      pnow_q     <= idx_ok && (c_after == beq_pkg::CNT_PRESS);
      qcnt_q     <= 4'(held_d);
    end else if (cmd_i.load_pop) begin
      ev_valid_q <= 1'b1;
      code_q     <= rd_data_q;
    end
  end

  assign event_valid_o  = ev_valid_q;
  assign event_code_o   = code_q;
  assign button_event_o = bev_q;
  assign dropped_o      = drop_q;
  assign pressed_now_o  = pnow_q;
  assign queue_count_o  = qcnt_q;

endmodule

[tb/button_event_queue_tb.sv]
// self-checking testbench for the button event queue
`timescale 1ns / 1ps

module button_event_queue_tb;

  // operation code the block leaves unused
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] LONG_PRESS_ADDR = 3'(4 * beq_pkg::REG_LONG_PRESS);
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned NUM_PHASES = 9;
  localparam int unsigned RANDOM_PHASE = 7;
  localparam int unsigned PRESSURE_PHASE = 1;

  // one result transaction
  typedef struct packed {
    logic       ev_valid;
    logic [7:0] code;
    logic [1:0] bev;
    logic       drop;
    logic       pnow;
    logic [3:0] count;
  } result_t;

  // one input transaction, with a hand-written result where one is known
  typedef struct packed {
    logic [1:0] op;
    logic [1:0] idx;
    logic       pin;
    logic [7:0] base;
    logic [7:0] value;
    logic       chk;
    result_t    golden;
  } stim_t;

  localparam result_t NO_GOLD = '0;

  // directed rows, run right after reset with the reset threshold of 100
  localparam stim_t DIRECTED [25] = '{
    '{beq_pkg::OP_POP,    2'd0, 1'b1, 8'h00, 8'h00, 1'b1,
      '{1'b0, 8'h00, beq_pkg::EV_NONE,  1'b0, 1'b0, 4'd0}},
    '{OP_UNUSED,          2'd3, 1'b1, 8'hFF, 8'hFF, 1'b1,
      '{1'b0, 8'h00, beq_pkg::EV_NONE,  1'b0, 1'b0, 4'd0}},
    '{beq_pkg::OP_PUSH,   2'd3, 1'b1, 8'h00, 8'hFF, 1'b1,
      '{1'b0, 8'h00, beq_pkg::EV_NONE,  1'b0, 1'b0, 4'd1}},
    '{beq_pkg::OP_PUSH,   2'd0, 1'b0, 8'hFF, 8'h00, 1'b1,
      '{1'b0, 8'h00, beq_pkg::EV_NONE,  1'b0, 1'b0, 4'd2}},
    '{beq_pkg::OP_SAMPLE, 2'd0, 1'b0, 8'hFF, 8'h00, 1'b1,
      '{1'b0, 8'h00, beq_pkg::EV_NONE,  1'b0, 1'b0, 4'd2}},
    '{beq_pkg::OP_SAMPLE, 2'd0, 1'b0, 8'hFF, 8'h00, 1'b1,
      '{1'b0, 8'h00, beq_pkg::EV_PRESS, 1'b0, 1'b1, 4'd3}},
    '{beq_pkg::OP_SAMPLE, 2'd0, 1'b0, 8'h00, 8'h00, 1'b0, NO_GOLD},
    '{beq_pkg::OP_SAMPLE, 2'd0, 1'b1, 8'h00, 8'h00, 1'b0, NO_GOLD},
    '{beq_pkg::OP_SAMPLE, 2'd0, 1'b1, 8'h80, 8'h00, 1'b0, NO_GOLD},
    '{beq_pkg::OP_PUSH,   2'd1, 1'b0, 8'h00, 8'hA5, 1'b0, NO_GOLD},
    '{beq_pkg::OP_PUSH,   2'd1, 1'b1, 8'h00, 8'h5A, 1'b0, NO_GOLD},
    '{beq_pkg::OP_PUSH,   2'd2, 1'b0, 8'h00, 8'h01, 1'b0, NO_GOLD},
    '{beq_pkg::OP_PUSH,   2'd2, 1'b1, 8'h00, 8'h80, 1'b0, NO_GOLD},
    '{beq_pkg::OP_PUSH,   2'd0, 1'b0, 8'h00, 8'h77, 1'b1,
      '{1'b0, 8'h00, beq_pkg::EV_NONE,  1'b1, 1'b0, 4'd8}},
    '{beq_pkg::OP_SAMPLE, 2'd3, 1'b0, 8'h10, 8'h00, 1'b0, NO_GOLD},
    '{beq_pkg::OP_SAMPLE, 2'd3, 1'b0, 8'h10, 8'h00, 1'b1,
      '{1'b0, 8'h00, beq_pkg::EV_PRESS, 1'b1, 1'b1, 4'd8}},
    '{beq_pkg::OP_POP,    2'd3, 1'b1, 8'h00, 8'h00, 1'b0, NO_GOLD},
    '{beq_pkg::OP_POP,    2'd1, 1'b1, 8'h00, 8'h00, 1'b0, NO_GOLD},
    '{beq_pkg::OP_POP,    2'd1, 1'b1, 8'h00, 8'h00, 1'b0, NO_GOLD},
    '{beq_pkg::OP_POP,    2'd1, 1'b1, 8'h00, 8'h00, 1'b0, NO_GOLD},
    '{beq_pkg::OP_POP,    2'd1, 1'b1, 8'h00, 8'h00, 1'b0, NO_GOLD},
    '{beq_pkg::OP_POP,    2'd1, 1'b1, 8'h00, 8'h00, 1'b0, NO_GOLD},
    '{beq_pkg::OP_POP,    2'd1, 1'b1, 8'h00, 8'h00, 1'b0, NO_GOLD},
    '{beq_pkg::OP_POP,    2'd1, 1'b1, 8'h00, 8'h00, 1'b0, NO_GOLD},
    '{beq_pkg::OP_POP,    2'd1, 1'b0, 8'hFF, 8'hFF, 1'b1,
      '{1'b0, 8'h00, beq_pkg::EV_NONE,  1'b0, 1'b0, 4'd0}}
  };

  // long-press thresholds per phase; the random phase draws its own
  localparam logic [7:0] LONG_SETTINGS [NUM_PHASES] = '{
    8'd3, 8'd2, 8'd250, 8'd0, 8'd1, 8'd255, 8'd251, 8'd37, 8'd100
  };
  localparam int IDLE_LEVELS [3] = '{0, 8, 25};
  localparam int POP_LEVELS [3] = '{5, 15, 30};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  operation_i;
  logic [1:0]  button_index_i;
  logic        pin_level_i;
  logic [7:0]  event_base_i;
  logic [7:0]  event_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        event_valid_o;
  logic [7:0]  event_code_o;
  logic [1:0]  button_event_o;
  logic        dropped_o;
  logic        pressed_now_o;
  logic [3:0]  queue_count_o;

  // hand-written result travelling with the current input transaction
  logic        golden_en;
  result_t     golden_res;

  // predictor state
  logic [7:0]  long_press_cfg = beq_pkg::LONG_PRESS_RESET;
  logic [7:0]  press_count [beq_pkg::NUM_BUTTONS_DEF];
  logic [7:0]  held_codes [$];
  result_t     awaited_results [$];

  // idling knobs
  int          gap_pct = 10;
  int          stall_pct = 10;
  int          pop_pct = 15;
  bit          idle_off = 1'b0;

  // press sequence under way in the random part
  logic [1:0]  hold_btn = 2'd0;
  int          hold_left = 0;
  int          release_left = 0;

  int unsigned accept_count = 0;
  int unsigned fail_count = 0;
  int unsigned n_items = 0, n_press = 0, n_long = 0, n_release = 0;
  int unsigned n_popped = 0, n_dropped = 0, n_settings = 0;

  button_event_queue u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .button_index_i (button_index_i),
    .pin_level_i    (pin_level_i),
    .event_base_i   (event_base_i),
    .event_value_i  (event_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_valid_o  (event_valid_o),
    .event_code_o   (event_code_o),
    .button_event_o (button_event_o),
    .dropped_o      (dropped_o),
    .pressed_now_o  (pressed_now_o),
    .queue_count_o  (queue_count_o)
  );

  // 20 ns clock
  always #10 clk_i = ~clk_i;

  function automatic string show(input result_t r);
    return $sformatf("valid=%0d code=%02h event=%0d dropped=%0d pressed=%0d count=%0d",
                     r.ev_valid, r.code, r.bev, r.drop, r.pnow, r.count);
  endfunction

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  // queue a code unless the event queue is full
  function automatic bit store_code(input logic [7:0] code);
    if (held_codes.size() >= beq_pkg::QUEUE_DEPTH_DEF) return 1'b0;
    held_codes.push_back(code);
    return 1'b1;
  endfunction

  // next state and result of the block for one input transaction
  function automatic result_t queue_outcome(input logic [1:0] op, input logic [1:0] idx,
                                            input logic pin, input logic [7:0] base,
                                            input logic [7:0] value);
    result_t    r;
    logic [7:0] c;
    logic [1:0] ev;
    r = '0;
    if (op == beq_pkg::OP_SAMPLE) begin
      if (idx < beq_pkg::NUM_BUTTONS_DEF) begin
        c = press_count[idx];
        ev = beq_pkg::EV_NONE;
        if (!pin) begin
          if (c < beq_pkg::CNT_MAX) c = c + 8'd1;
          if (c == beq_pkg::CNT_PRESS) ev = beq_pkg::EV_PRESS;
          else if (c == long_press_cfg) ev = beq_pkg::EV_LONG;
        end else if (c == 8'd1) begin
          c = 8'd0;
          ev = beq_pkg::EV_RELEASE;
        end else if (c > 8'd1) begin
          c = 8'd1;
        end
        press_count[idx] = c;
        r.bev = ev;
        if (ev != beq_pkg::EV_NONE) r.drop = !store_code({6'd0, ev} + base);
      end
    end else if (op == beq_pkg::OP_POP) begin
      if (held_codes.size() > 0) begin
        r.ev_valid = 1'b1;
        r.code = held_codes.pop_front();
      end
    end else if (op == beq_pkg::OP_PUSH) begin
      r.drop = !store_code(value);
    end
    r.pnow = (idx < beq_pkg::NUM_BUTTONS_DEF) && (press_count[idx] == beq_pkg::CNT_PRESS);
    r.count = 4'(held_codes.size());
    return r;
  endfunction

  // random transaction: mostly press, hold and release runs, the rest noise
  function automatic stim_t random_transaction();
    stim_t s;
    int    r;
    s = '0;
    s.base = 8'($urandom_range(0, 255));
    s.value = 8'($urandom_range(0, 255));
    s.idx = 2'($urandom_range(0, 3));
    s.pin = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < pop_pct) begin
      s.op = beq_pkg::OP_POP;
    end else if (r < pop_pct + 6) begin
      s.op = beq_pkg::OP_PUSH;
    end else if (r < pop_pct + 8) begin
      s.op = OP_UNUSED;
    end else if (r < pop_pct + 12) begin
      // stray sample that does not break a long hold
      s.op = beq_pkg::OP_SAMPLE;
      if (s.idx == hold_btn && hold_left > 0) s.pin = 1'b0;
    end else begin
      s.op = beq_pkg::OP_SAMPLE;
      if (hold_left == 0 && release_left == 0) begin
        hold_btn = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 55) begin
          hold_left = $urandom_range(1, 4);
        end else if (r < 96) begin
          if (long_press_cfg >= 8'd3 && long_press_cfg <= beq_pkg::CNT_MAX)
            hold_left = int'(long_press_cfg) + $urandom_range(0, 3);
          else
            hold_left = $urandom_range(5, 20);
        end else begin
          hold_left = $urandom_range(250, 260);
        end
        // now and then the release is cut short
        release_left = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : 2;
      end
      s.idx = hold_btn;
      if (hold_left > 0) begin
        s.pin = 1'b0;
        hold_left--;
      end else begin
        s.pin = 1'b1;
        release_left--;
      end
    end
    return s;
  endfunction

  // drive one input transaction and wait for it to be taken
  task automatic send_item(input stim_t s);
    if (!idle_off && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= s.op;
    button_index_i <= s.idx;
    pin_level_i <= s.pin;
    event_base_i <= s.base;
    event_value_i <= s.value;
    golden_en <= s.chk;
    golden_res <= s.golden;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // write the long-press threshold, then read it back
  task automatic set_long_press(input logic [7:0] ticks);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LONG_PRESS_ADDR;
    pwdata <= {24'd0, ticks};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    long_press_cfg = ticks;
    n_settings++;
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[7:0] !== ticks)
      log_failure($sformatf("long_press_ticks read %02h, wrote %02h", prdata[7:0], ticks));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // result checking and prediction, both on accepted transactions
  always @(posedge clk_i) begin : scoreboard
    result_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        accept_count++;
        got = '{event_valid_o, event_code_o, button_event_o, dropped_o, pressed_now_o,
                queue_count_o};
        if (awaited_results.size() == 0) begin
          log_failure({"result with nothing pending: ", show(got)});
        end else begin
          want = awaited_results.pop_front();
          if (got !== want)
            log_failure({"expected ", show(want), " got ", show(got)});
        end
      end
      if (in_valid_i && !in_stall_o) begin
        accept_count++;
        want = queue_outcome(operation_i, button_index_i, pin_level_i, event_base_i,
                             event_value_i);
        if (golden_en) want = golden_res;
        n_items++;
        if (want.bev == beq_pkg::EV_PRESS) n_press++;
        if (want.bev == beq_pkg::EV_LONG) n_long++;
        if (want.bev == beq_pkg::EV_RELEASE) n_release++;
        if (want.ev_valid) n_popped++;
        if (want.drop) n_dropped++;
        awaited_results.push_back(want);
      end
    end
  end

  // receiver stall bursts
  initial begin : stall_gen
    int burst;
    burst = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_off) begin
        out_stall_i <= 1'b0;
        burst = 0;
      end else if (burst > 0) begin
        out_stall_i <= 1'b1;
        burst--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        burst = $urandom_range(1, 13) - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transaction
  initial begin : watchdog
    int unsigned last_seen, quiet;
    last_seen = 0;
    quiet = 0;
    forever begin
      @(negedge clk_i);
      if (accept_count != last_seen) begin
        last_seen = accept_count;
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("button_event_queue verification failed");
        $finish;
      end
    end
  end

  // stimulus: reset, directed rows, then random phases per threshold
  initial begin : stimulus
    stim_t       s;
    logic [7:0]  ticks;
    int unsigned budget, sent;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    operation_i = beq_pkg::OP_SAMPLE;
    button_index_i = '0;
    pin_level_i = 1'b1;
    event_base_i = '0;
    event_value_i = '0;
    golden_en = 1'b0;
    golden_res = '0;
    foreach (press_count[i]) press_count[i] = '0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) send_item(DIRECTED[i]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      ticks = LONG_SETTINGS[ph];
      if (ph == RANDOM_PHASE) ticks = 8'($urandom_range(3, 250));
      // drain before touching the register
      in_valid_i <= 1'b0;
      wait (awaited_results.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      set_long_press(ticks);

      // last phase runs without idling
      idle_off = (ph == NUM_PHASES - 1);
      gap_pct = IDLE_LEVELS[$urandom_range(0, 2)];
      stall_pct = IDLE_LEVELS[$urandom_range(0, 2)];
      pop_pct = POP_LEVELS[$urandom_range(0, 2)];

      // high thresholds get one hold long enough to reach them
      hold_left = 0;
      release_left = 0;
      if (ticks >= 8'd200 && ticks <= beq_pkg::CNT_MAX) begin
        hold_btn = 2'($urandom_range(0, 3));
        hold_left = int'(ticks) + 3;
        release_left = 2;
      end

      budget = (ticks == beq_pkg::CNT_MAX) ? 350 : 185;
      sent = 0;
      while (sent < budget) begin
        s = random_transaction();
        if (s.op != OP_UNUSED) sent++;
        send_item(s);
        // hold off until every pending result is out
        if (ph == PRESSURE_PHASE && sent == budget / 2) begin
          in_valid_i <= 1'b0;
          wait (awaited_results.size() == 0);
          @(negedge clk_i);
        end
      end
    end

    in_valid_i <= 1'b0;
    idle_off = 1'b1;
    wait (awaited_results.size() == 0);
    repeat (8) @(posedge clk_i);

    $display("%0d transactions checked: %0d presses, %0d long presses, %0d releases",
             n_items, n_press, n_long, n_release);
    $display("%0d codes popped, %0d pushes dropped, %0d long-press thresholds written",
             n_popped, n_dropped, n_settings);
    if (fail_count == 0) begin
      $display("button_event_queue verification clean");
    end else begin
      $display("button_event_queue verification failed");
    end
    $finish;
  end

endmodule

[button_event_queue.f]
hw/rtl/beq_pkg.sv
hw/rtl/beq_ctrl.sv
hw/rtl/beq_datapath.sv
hw/rtl/button_event_queue.sv
tb/button_event_queue_tb.sv
